[rtl/core/hsc_pkg.sv]
// ----------------------------------------------------------------------------
// hsc_pkg: shared definitions for the Hamming SEC codec
// Field widths, operation and status codes, and the fixed bit mappings of
// the codeword: message scatter, syndrome tree and parity count.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int MaxMessageBits = 57;
  localparam int MsgW           = 57;
  localparam int CodeW          = 63;
  localparam int SynW           = 6;
  localparam int CfgW           = 6;
  localparam logic [CfgW-1:0] MsgBitsReset = 6'd57;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_CHECK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_BEYOND    = 2'd2
  } status_e;

  // Place message bits in ascending order into the non-power-of-two positions
  function automatic logic [CodeW-1:0] scatter_msg(input logic [MsgW-1:0] msg);
    logic [CodeW-1:0] w;
    int               k;
    w = '0;
    k = 0;
    for (int p = 1; p <= CodeW; p++) begin
      if ((p & (p - 1)) != 0) begin
        w[p-1] = msg[k];
        k++;
      end
    end
    return w;
  endfunction

  // XOR of the positions of all set bits
  function automatic logic [SynW-1:0] syndrome_of(input logic [CodeW-1:0] w);
    logic [SynW-1:0] s;
    s = '0;
    for (int p = 1; p <= CodeW; p++) begin
      if (w[p-1]) begin
        s = s ^ SynW'(p);
      end
    end
    return s;
  endfunction

  // Smallest r with m + r + 1 <= 2^r
  function automatic logic [2:0] parity_count(input logic [CfgW-1:0] m);
    logic [2:0] r;
    r = 3'd6;
    for (int k = 5; k >= 0; k--) begin
      if (int'(m) + k + 1 <= (1 << k)) begin
        r = 3'(k);
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/hamming_sec_codec_core.sv]
// ----------------------------------------------------------------------------
// hamming_sec_codec_core: pipelined Hamming single-error-correcting codec
// Encodes a message or checks and corrects a received codeword, even parity,
// with the codeword length set by the message_bits register.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_axis_tuser_i selects encode or check, s_axis_tdata_i
//   carries the message and the received codeword. Output stream:
//   m_axis_tdata_o carries the codeword, the syndrome and the status.
//   One result item leaves for every input item, in order.
//   An item passes three register stages (scatter and mask, syndrome XOR
//   tree, correction and parity insert), and m_axis_tvalid_o rises when it
//   reaches the third; throughput is one item per cycle while the receiver
//   does not hold m_axis_tready_i low.
//   The APB port holds message_bits (byte address 0); write it only while no
//   item is in flight.
//   Reset empties the pipeline and sets message_bits to 57.
//   When the receiver holds m_axis_tready_i low with a result waiting, the
//   whole pipeline holds and s_axis_tready_o falls in the same cycle; nothing
//   is dropped or repeated.
// ----------------------------------------------------------------------------
module hamming_sec_codec_core #(
  parameter int MAX_MESSAGE_BITS = hsc_pkg::MaxMessageBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB configuration port
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [2:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  output logic [31:0]  prdata_o,
  output logic         pready_o,
  // input stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [119:0] s_axis_tdata_i,   // [56:0] message, [119:57] received
  input  logic         s_axis_tuser_i,   // [0] op
  // output stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [71:0]  m_axis_tdata_o    // [62:0] codeword, [68:63] syndrome,
                                         // [70:69] status, [71] zero
);

  localparam logic [hsc_pkg::CfgW-1:0] MaxM = hsc_pkg::CfgW'(MAX_MESSAGE_BITS);

  // configuration
  logic [hsc_pkg::CfgW-1:0]  message_bits_q;
  logic [hsc_pkg::CfgW-1:0]  m_eff;
  logic [2:0]                r_cnt;
  logic [hsc_pkg::SynW-1:0]  n_len;
  logic [hsc_pkg::CodeW-1:0] n_mask;
  logic [hsc_pkg::MsgW-1:0]  m_mask;
  logic                      cfg_wr;

  // pipeline
  logic                      en;
  logic                      v1_q, v2_q, v3_q;
  hsc_pkg::op_e              op1_q, op2_q;
  logic [hsc_pkg::CodeW-1:0] w1_d, w1_q, w2_q;
  logic [hsc_pkg::SynW-1:0]  syn2_q;
  logic [hsc_pkg::CodeW-1:0] cw3_d, cw3_q;
  logic [hsc_pkg::SynW-1:0]  syn3_d, syn3_q;
  hsc_pkg::status_e          st3_d, st3_q;
  hsc_pkg::op_e              op_in;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i & ~paddr_i[2];
  assign prdata_o = paddr_i[2] ? 32'd0 : {26'd0, message_bits_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      message_bits_q <= hsc_pkg::MsgBitsReset;
    end else if (cfg_wr) begin
      message_bits_q <= pwdata_i[hsc_pkg::CfgW-1:0];
    end
  end

  always_comb begin
    if (message_bits_q == '0) begin
      m_eff = hsc_pkg::CfgW'(1);
    end else if (message_bits_q > MaxM) begin
      m_eff = MaxM;
    end else begin
      m_eff = message_bits_q;
    end
    r_cnt = hsc_pkg::parity_count(m_eff);
    n_len = m_eff + hsc_pkg::SynW'(r_cnt);
    for (int i = 0; i < hsc_pkg::CodeW; i++) begin
      n_mask[i] = (i < int'(n_len));
    end
    for (int i = 0; i < hsc_pkg::MsgW; i++) begin
      m_mask[i] = (i < int'(m_eff));
    end
  end

  // advance the whole pipeline unless a finished result is held
  assign en              = ~v3_q | m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign op_in           = hsc_pkg::op_e'(s_axis_tuser_i);

  // stage 1: build the working word
  always_comb begin
    if (op_in == hsc_pkg::OP_CHECK) begin
      w1_d = s_axis_tdata_i[119:57] & n_mask;
    end else begin
      w1_d = hsc_pkg::scatter_msg(s_axis_tdata_i[56:0] & m_mask);
    end
  end

  // stage 3: parity insert or correction
  always_comb begin
    cw3_d  = w2_q;
    syn3_d = '0;
    st3_d  = hsc_pkg::ST_OK;
    case (op2_q)
      hsc_pkg::OP_ENCODE: begin
        for (int t = 0; t < hsc_pkg::SynW; t++) begin
          if (syn2_q[t]) begin
            cw3_d[(1 << t) - 1] = 1'b1;
          end
        end
      end
      hsc_pkg::OP_CHECK: begin
        syn3_d = syn2_q;
        if (syn2_q == '0) begin
          st3_d = hsc_pkg::ST_OK;
        end else if (syn2_q <= n_len) begin
          st3_d = hsc_pkg::ST_CORRECTED;
          for (int i = 0; i < hsc_pkg::CodeW; i++) begin
            if (syn2_q == hsc_pkg::SynW'(i + 1)) begin
              cw3_d[i] = ~w2_q[i];
            end
          end
        end else begin
          st3_d = hsc_pkg::ST_BEYOND;
        end
      end
      default: begin
        st3_d = hsc_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q  <= op_in;
      w1_q   <= w1_d;
      op2_q  <= op1_q;
      w2_q   <= w1_q;
      syn2_q <= hsc_pkg::syndrome_of(w1_q);
      cw3_q  <= cw3_d;
      syn3_q <= syn3_d;
      st3_q  <= st3_d;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = {1'b0, st3_q, syn3_q, cw3_q};

  // a clean result carries no syndrome
  a_ok_no_syn : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && st3_q == hsc_pkg::ST_OK) |-> syn3_q == '0)
    else $error("status OK with non-zero syndrome");

  // a correction or an overrun needs a syndrome
  a_err_syn : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && st3_q != hsc_pkg::ST_OK) |-> syn3_q != '0)
    else $error("error status with zero syndrome");

  // a result only appears from a filled second stage
  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v3_q) |-> $past(v2_q))
    else $error("result appeared without an item in stage 2");

endmodule
